// File: rtl/bbss_pkg.sv
`timescale 1ns / 1ps

package bbss_pkg;

	// Default sizes of the tables and of the probe window.
	localparam int DEF_VOCAB_SIZE   = 65536;
	localparam int DEF_BIGRAM_SLOTS = 65536;
	localparam int DEF_MAX_PROBES   = 16;

	// Field widths.
	localparam int WORD_W  = 16;
	localparam int KEY_W   = 2 * WORD_W;
	localparam int VAL_W   = 32;
	localparam int PAIR_W  = 34;
	localparam int TOTAL_W = 48;

	// Multiplicative hash constant for the bigram key.
	localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B1;

	// Saturation limits of the sentence total.
	localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
	localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

	// Configuration register map.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_IDX = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_IDX   = 1'b1;
	localparam logic [WORD_W-1:0] START_ID_RST = 16'd1;
	localparam logic [WORD_W-1:0] END_ID_RST   = 16'd2;

	typedef enum logic [1:0] {
		OP_LOAD_UNI  = 2'd0,
		OP_INSERT_BI = 2'd1,
		OP_SCORE     = 2'd2,
		OP_END       = 2'd3
	} op_t;

endpackage

// File: rtl/bbss_hash.sv
`timescale 1ns / 1ps

// Two-stage multiplicative hash: the low word of key * HASH_MULT, then the
// top bits of that word scaled by the table size give the home slot.
module bbss_hash
	import bbss_pkg::*;
#(
	parameter int BIGRAM_SLOTS = DEF_BIGRAM_SLOTS,
	localparam int SLOT_W = $clog2(BIGRAM_SLOTS)
) (
	input  logic              clk,
	input  logic [KEY_W-1:0]  key,
	output logic [SLOT_W-1:0] slot
);

	localparam logic [63:0] SLOTS_C = 64'(BIGRAM_SLOTS);

	logic [KEY_W-1:0]  h_s1;
	logic [SLOT_W-1:0] slot_s2;
	logic [63:0]       prod;

	assign prod = {32'd0, h_s1} * SLOTS_C;

	always_ff @(posedge clk) begin
		h_s1    <= key * HASH_MULT;
		slot_s2 <= prod[32 +: SLOT_W];
	end

	assign slot = slot_s2;

endmodule

// File: rtl/bigram_backoff_sentence_scorer.sv
`timescale 1ns / 1ps
// Sequence: a unigram load goes from idle straight to its finish state. Inserts, score and
// end items pass through S_HASH1, S_HASH2 and S_PROBE_RD, then S_PROBE for the k bigram
// slots probed (1 to MAX_PROBES) at one slot per cycle, then S_FINISH; a stalled result
// holds the next item in its finish state.
// Reset: all control clears, then a clearing pass over max(VOCAB_SIZE,
// BIGRAM_SLOTS) addresses zeroes both memories with in_stall high.
module bigram_backoff_sentence_scorer
	import bbss_pkg::*;
#(
	parameter int VOCAB_SIZE   = DEF_VOCAB_SIZE,
	parameter int BIGRAM_SLOTS = DEF_BIGRAM_SLOTS,
	parameter int MAX_PROBES   = DEF_MAX_PROBES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                opcode,
	input  logic [WORD_W-1:0]         word_id,
	input  logic [WORD_W-1:0]         second_word_id,
	input  logic signed [VAL_W-1:0]   log_prob,
	input  logic signed [VAL_W-1:0]   backoff_weight,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      status,
	output logic signed [PAIR_W-1:0]  pair_score,
	output logic                      backed_off,
	output logic signed [TOTAL_W-1:0] sentence_score,
	output logic                      sentence_done,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [WORD_W-1:0]         cfg_wdata
);

	localparam int VOCAB_W   = $clog2(VOCAB_SIZE);
	localparam int SLOT_W    = $clog2(BIGRAM_SLOTS);
	localparam int PROBE_W   = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
	localparam int CLR_DEPTH = (VOCAB_SIZE > BIGRAM_SLOTS) ? VOCAB_SIZE : BIGRAM_SLOTS;
	localparam int CLR_W     = $clog2(CLR_DEPTH);
	localparam logic [31:0]        VOCAB_LIMIT = 32'(VOCAB_SIZE);
	localparam logic [31:0]        SLOTS_LIMIT = 32'(BIGRAM_SLOTS);
	localparam logic [SLOT_W:0]    SLOT_LIMIT  = (SLOT_W+1)'(BIGRAM_SLOTS);
	localparam logic [PROBE_W-1:0] PROBE_LAST  = PROBE_W'(MAX_PROBES - 1);
	localparam logic [CLR_W-1:0]   CLR_LAST    = CLR_W'(CLR_DEPTH - 1);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_PROBE_RD, S_PROBE, S_FINISH
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} bi_entry_t;

	// Memories: unigram entries hold {log_prob, backoff}.
	logic [2*VAL_W-1:0] uni_mem [VOCAB_SIZE];
	bi_entry_t          bi_mem  [BIGRAM_SLOTS];

	state_t state_q;
	logic [CLR_W-1:0]   clr_q;
	logic [PROBE_W-1:0] probe_cnt_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               found_q;
	logic               free_q;
	op_t                op_q;

	logic [WORD_W-1:0]  start_q;
	logic [WORD_W-1:0]  end_q;
	logic [WORD_W-1:0]  prev_q;
	logic               at_start_q;
	logic signed [TOTAL_W-1:0] running_q;

	logic               out_valid_q;
	logic               status_q;
	logic signed [PAIR_W-1:0]  pair_q;
	logic               backed_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic               done_q;

	// Item payload, no reset.
	logic [KEY_W-1:0]   key_q;
	logic [WORD_W-1:0]  ctx_q;
	logic [WORD_W-1:0]  cur_q;
	logic               ctx_ok_q;
	logic               cur_ok_q;
	logic [VAL_W-1:0]   lp_in_q;
	logic [VAL_W-1:0]   bo_in_q;
	logic signed [VAL_W-1:0]  bo_q;
	logic signed [VAL_W-1:0]  lp_q;
	logic signed [VAL_W-1:0]  val_q;
	logic signed [PAIR_W-1:0] bsum_q;

	logic [2*VAL_W-1:0] uni_rd_q;
	bi_entry_t          bi_rd_q;

	logic [SLOT_W-1:0]  home_slot;
	logic [SLOT_W-1:0]  slot_nx;
	logic               hit_c;
	logic               empty_c;
	logic               stop_c;
	logic               fin_go;
	logic               scoring;
	logic [WORD_W-1:0]  ctx_c;
	logic [WORD_W-1:0]  cur_c;
	logic signed [PAIR_W-1:0]  pair_c;
	logic [TOTAL_W:0]          sum_c;
	logic signed [TOTAL_W-1:0] sat_c;

	logic               uni_we;
	logic [VOCAB_W-1:0] uni_waddr;
	logic [2*VAL_W-1:0] uni_wdata;
	logic [VOCAB_W-1:0] uni_raddr;
	logic               bi_we;
	logic [SLOT_W-1:0]  bi_waddr;
	bi_entry_t          bi_wdata;
	logic [SLOT_W-1:0]  bi_raddr;

	bbss_hash #(
		.BIGRAM_SLOTS(BIGRAM_SLOTS)
	) u_hash (
		.clk (clk),
		.key (key_q),
		.slot(home_slot)
	);

	assign in_stall = (state_q != S_IDLE);

	assign ctx_c = at_start_q ? start_q : prev_q;
	assign cur_c = (op_t'(opcode) == OP_END) ? end_q : word_id;

	assign slot_nx = (({1'b0, slot_q} + 1'b1) >= SLOT_LIMIT) ? '0 : slot_q + 1'b1;

	assign hit_c   = bi_rd_q.valid && (bi_rd_q.key == key_q);
	assign empty_c = !bi_rd_q.valid;
	assign stop_c  = hit_c || empty_c || (probe_cnt_q == PROBE_LAST);

	assign fin_go  = (state_q == S_FINISH) && (!out_valid_q || !out_stall);
	assign scoring = (op_q == OP_SCORE) || (op_q == OP_END);

	assign pair_c = found_q ? {{(PAIR_W-VAL_W){val_q[VAL_W-1]}}, val_q} : bsum_q;
	assign sum_c  = {running_q[TOTAL_W-1], running_q}
		+ {{(TOTAL_W+1-PAIR_W){pair_c[PAIR_W-1]}}, pair_c};

	always_comb begin
		if (sum_c[TOTAL_W] != sum_c[TOTAL_W-1]) begin
			sat_c = sum_c[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
		end else begin
			sat_c = sum_c[TOTAL_W-1:0];
		end
	end

	// Memory port control.
	always_comb begin
		uni_we    = 1'b0;
		uni_waddr = cur_q[VOCAB_W-1:0];
		uni_wdata = {lp_in_q, bo_in_q};
		bi_we     = 1'b0;
		bi_waddr  = slot_q;
		bi_wdata  = '{valid: 1'b1, key: key_q, value: lp_in_q};
		if (state_q == S_CLEAR) begin
			uni_we    = (32'(clr_q) < VOCAB_LIMIT);
			uni_waddr = clr_q[VOCAB_W-1:0];
			uni_wdata = '0;
			bi_we     = (32'(clr_q) < SLOTS_LIMIT);
			bi_waddr  = clr_q[SLOT_W-1:0];
			bi_wdata  = '0;
		end else if (fin_go) begin
			uni_we = (op_q == OP_LOAD_UNI) && cur_ok_q;
			bi_we  = (op_q == OP_INSERT_BI) && (found_q || free_q);
		end
		uni_raddr = (state_q == S_HASH1) ? ctx_q[VOCAB_W-1:0] : cur_q[VOCAB_W-1:0];
		bi_raddr  = (state_q == S_PROBE_RD) ? home_slot : slot_nx;
	end

	always_ff @(posedge clk) begin
		if (uni_we) begin
			uni_mem[uni_waddr] <= uni_wdata;
		end
		uni_rd_q <= uni_mem[uni_raddr];
	end

	always_ff @(posedge clk) begin
		if (bi_we) begin
			bi_mem[bi_waddr] <= bi_wdata;
		end
		bi_rd_q <= bi_mem[bi_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_ID_RST;
			end_q   <= END_ID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_IDX: start_q <= cfg_wdata;
				CFG_END_IDX:   end_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Datapath registers of the item in flight.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			ctx_q    <= ctx_c;
			cur_q    <= cur_c;
			ctx_ok_q <= ({16'd0, ctx_c} < VOCAB_LIMIT);
			cur_ok_q <= ({16'd0, cur_c} < VOCAB_LIMIT);
			key_q    <= (op_t'(opcode) == OP_INSERT_BI) ? {word_id, second_word_id}
				: {ctx_c, cur_c};
			lp_in_q  <= log_prob;
			bo_in_q  <= backoff_weight;
		end
		if (state_q == S_HASH2) begin
			bo_q <= ctx_ok_q ? uni_rd_q[VAL_W-1:0] : '0;
		end
		if (state_q == S_PROBE_RD) begin
			lp_q <= cur_ok_q ? uni_rd_q[2*VAL_W-1:VAL_W] : '0;
		end
		if (state_q == S_PROBE) begin
			val_q  <= bi_rd_q.value;
			bsum_q <= {{(PAIR_W-VAL_W){bo_q[VAL_W-1]}}, bo_q}
				+ {{(PAIR_W-VAL_W){lp_q[VAL_W-1]}}, lp_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			probe_cnt_q <= '0;
			slot_q      <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			op_q        <= OP_LOAD_UNI;
			prev_q      <= START_ID_RST;
			at_start_q  <= 1'b1;
			running_q   <= '0;
			out_valid_q <= 1'b0;
			status_q    <= 1'b0;
			pair_q      <= '0;
			backed_q    <= 1'b0;
			total_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op_t'(opcode);
						state_q <= (op_t'(opcode) == OP_LOAD_UNI) ? S_FINISH : S_HASH1;
					end
				end
				S_HASH1: state_q <= S_HASH2;
				S_HASH2: state_q <= S_PROBE_RD;
				S_PROBE_RD: begin
					slot_q      <= home_slot;
					probe_cnt_q <= '0;
					state_q     <= S_PROBE;
				end
				S_PROBE: begin
					// The read for the next slot is already issued when the probe goes on.
					if (stop_c) begin
						found_q <= hit_c;
						free_q  <= empty_c;
						state_q <= S_FINISH;
					end else begin
						slot_q      <= slot_nx;
						probe_cnt_q <= probe_cnt_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						status_q    <= (op_q == OP_INSERT_BI) && !found_q && !free_q;
						pair_q      <= scoring ? pair_c : '0;
						backed_q    <= scoring && !found_q;
						total_q     <= scoring ? sat_c : running_q;
						done_q      <= (op_q == OP_END);
						if (op_q == OP_SCORE) begin
							running_q  <= sat_c;
							prev_q     <= cur_q;
							at_start_q <= 1'b0;
						end else if (op_q == OP_END) begin
							running_q  <= '0;
							prev_q     <= start_q;
							at_start_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign pair_score     = pair_q;
	assign backed_off     = backed_q;
	assign sentence_score = total_q;
	assign sentence_done  = done_q;

	// A finished result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_valid_q && out_stall) |=> (state_q == S_FINISH))
		else $error("result register overwritten while stalled");

	// Probing stays inside the table and inside the probe window.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> ({1'b0, slot_q} < SLOT_LIMIT && probe_cnt_q <= PROBE_LAST))
		else $error("bigram probe out of range");

	// An end item leaves a fresh sentence behind it.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && op_q == OP_END) |=> (at_start_q && running_q == '0))
		else $error("sentence state not reset after end item");

	// A dropped insert never carries a score.
	a_status_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (!done_q && !backed_q && pair_q == '0))
		else $error("status set on a scoring result");

	// Running total only moves on score or end items.
	a_total_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && (op_q == OP_LOAD_UNI || op_q == OP_INSERT_BI)) |=> $stable(running_q))
		else $error("load item changed the running total");

endmodule
